/* design/skf_pkg.sv */
// Shared types and constants for the scalar Kalman smoother.
`default_nettype none
package skf_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int GAIN_W     = FRAC_BITS;
    localparam int MUL_A_W    = DATA_WIDTH + 1;
    localparam int MUL_B_W    = FRAC_BITS + 1;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int DIV_CNT_W  = $clog2(FRAC_BITS);

    localparam logic [MUL_B_W-1:0]    GAIN_ONE = MUL_B_W'(1) << FRAC_BITS;
    localparam logic [GAIN_W-1:0]     GAIN_MAX = '1;
    localparam logic [DIV_CNT_W-1:0]  DIV_LAST = DIV_CNT_W'(FRAC_BITS - 1);

    localparam logic [DATA_WIDTH-1:0] PROC_VAR_RST = DATA_WIDTH'(655);
    localparam logic [DATA_WIDTH-1:0] MEAS_VAR_RST = DATA_WIDTH'(346685);
    localparam logic [DATA_WIDTH-1:0] INIT_VAR_RST = DATA_WIDTH'(6553600);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROC_VAR = 2'd0,
        REG_MEAS_VAR = 2'd1,
        REG_INIT_VAR = 2'd2
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PRED,
        S_SUM,
        S_DIV,
        S_MUL_EST,
        S_MUL_VAR,
        S_VAR_WB,
        S_OUT
    } t_state;

    typedef struct packed {
        logic capture;
        logic load_first;
        logic pred;
        logic sum;
        logic div_step;
        logic mul_est;
        logic mul_var;
        logic var_wb;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic restart;
        logic out_free;
    } t_status;

endpackage
`default_nettype wire

/* design/skf_ctrl.sv */
// Sequencer for one filter update: predict, divide, two multiplies, write back, or a restart load.
`default_nettype none
module skf_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_stall,
    input  skf_pkg::t_status i_status,
    output skf_pkg::t_cmd    o_cmd
);
    import skf_pkg::*;

    t_state               r_state, n_state;
    logic [DIV_CNT_W-1:0] r_count, n_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_PRED;
            end
            S_PRED: begin
                n_state = i_status.restart ? S_OUT : S_SUM;
            end
            S_SUM: begin
                n_state = S_DIV;
                n_count = '0;
            end
            S_DIV: begin
                n_count = r_count + 1'b1;
                if (r_count == DIV_LAST) n_state = S_MUL_EST;
            end
            S_MUL_EST: n_state = S_MUL_VAR;
            S_MUL_VAR: n_state = S_VAR_WB;
            S_VAR_WB:  n_state = S_OUT;
            S_OUT: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall    = 1'b0;
                o_cmd.capture = i_in_valid;
            end
            S_PRED: begin
                o_cmd.load_first = i_status.restart;
                o_cmd.pred       = !i_status.restart;
            end
            S_SUM:     o_cmd.sum      = 1'b1;
            S_DIV:     o_cmd.div_step = 1'b1;
            S_MUL_EST: o_cmd.mul_est  = 1'b1;
            S_MUL_VAR: o_cmd.mul_var  = 1'b1;
            S_VAR_WB:  o_cmd.var_wb   = 1'b1;
            S_OUT:     o_cmd.out_load = i_status.out_free;
            default:   o_cmd          = '0;
        endcase
    end

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_PRED))
        else $error("accepted beat did not start an update");

    a_div_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_count == DIV_LAST) |=> (r_state == S_MUL_EST))
        else $error("divider ran the wrong number of steps");

    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_in_stall)
        else $error("input taken while an update is in flight");

endmodule
`default_nettype wire

/* design/skf_dp.sv */
// Filter datapath: config registers, state, serial divider, shared multiplier.
`default_nettype none
module skf_dp (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_cfg_valid,
    input  wire  [skf_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire  [skf_pkg::DATA_WIDTH-1:0]        i_cfg_data,
    input  wire  signed [skf_pkg::DATA_WIDTH-1:0] i_sample,
    input  wire                                   i_first,
    input  wire                                   i_out_stall,
    output logic                                  o_out_valid,
    output logic signed [skf_pkg::DATA_WIDTH-1:0] o_estimate,
    input  skf_pkg::t_cmd                         i_cmd,
    output skf_pkg::t_status                      o_status
);
    import skf_pkg::*;

    logic [DATA_WIDTH-1:0] r_proc_var, r_meas_var, r_init_var;
    logic [DATA_WIDTH-1:0] r_est, r_var;
    logic                  r_started;
    logic [DATA_WIDTH-1:0] r_sample;
    logic                  r_first;
    logic [DATA_WIDTH-1:0] r_pred, r_sum, r_rem;
    logic [DATA_WIDTH:0]   r_diff;
    logic [GAIN_W-1:0]     r_quot;
    logic                  r_sat;
    logic [PROD_W-1:0]     r_prod;
    logic [DATA_WIDTH-1:0] r_out;
    logic                  r_out_valid;

    function automatic logic [DATA_WIDTH-1:0] sat_add(input logic [DATA_WIDTH-1:0] a,
                                                      input logic [DATA_WIDTH-1:0] b);
        logic [DATA_WIDTH:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[DATA_WIDTH] ? '1 : s[DATA_WIDTH-1:0];
    endfunction

    logic [DATA_WIDTH-1:0] pred_c, sum_c;
    logic [DATA_WIDTH:0]   shl_c, mag_c, est_ext, est_next;
    logic [GAIN_W-1:0]     gain_c;
    logic [MUL_A_W-1:0]    mul_a;
    logic [MUL_B_W-1:0]    mul_b;
    logic [DATA_WIDTH-1:0] corr_c;
    logic                  div_ge;

    assign pred_c  = sat_add(r_var, r_proc_var);
    assign sum_c   = sat_add(r_pred, r_meas_var);
    assign shl_c   = {r_rem, 1'b0};
    assign div_ge  = (shl_c >= {1'b0, r_sum});
    assign gain_c  = r_sat ? GAIN_MAX : r_quot;
    assign mag_c   = r_diff[DATA_WIDTH] ? (~r_diff + 1'b1) : r_diff;
    assign corr_c  = r_prod[FRAC_BITS +: DATA_WIDTH];
    assign est_ext = {r_est[DATA_WIDTH-1], r_est};
    assign est_next = r_diff[DATA_WIDTH] ? (est_ext - {1'b0, corr_c})
                                         : (est_ext + {1'b0, corr_c});

    // one multiplier, shared by the estimate and variance updates
    assign mul_a = i_cmd.mul_est ? mag_c : {1'b0, r_pred};
    assign mul_b = i_cmd.mul_est ? {1'b0, gain_c} : (GAIN_ONE - {1'b0, gain_c});

    assign o_status.restart  = r_first || !r_started;
    assign o_status.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_estimate  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_proc_var  <= PROC_VAR_RST;
            r_meas_var  <= MEAS_VAR_RST;
            r_init_var  <= INIT_VAR_RST;
            r_est       <= '0;
            r_var       <= INIT_VAR_RST;
            r_started   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_PROC_VAR: r_proc_var <= i_cfg_data;
                    REG_MEAS_VAR: r_meas_var <= i_cfg_data;
                    REG_INIT_VAR: r_init_var <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.load_first) begin
                r_est     <= r_sample;
                r_var     <= r_init_var;
                r_started <= 1'b1;
            end
            if (i_cmd.mul_var) r_est <= est_next[DATA_WIDTH-1:0];
            if (i_cmd.var_wb)  r_var <= r_prod[FRAC_BITS +: DATA_WIDTH];
            if (i_cmd.out_load)
                r_out_valid <= 1'b1;
            else if (!i_out_stall)
                r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_sample <= i_sample;
            r_first  <= i_first;
        end
        if (i_cmd.pred) begin
            r_pred <= pred_c;
            r_diff <= {r_sample[DATA_WIDTH-1], r_sample} - est_ext;
        end
        if (i_cmd.sum) begin
            r_sum  <= sum_c;
            r_rem  <= r_pred;
            r_quot <= '0;
            r_sat  <= (r_pred >= sum_c);
        end
        // restoring division, one quotient bit per cycle
        if (i_cmd.div_step) begin
            r_quot <= {r_quot[GAIN_W-2:0], div_ge};
            r_rem  <= div_ge ? (shl_c[DATA_WIDTH-1:0] - r_sum) : shl_c[DATA_WIDTH-1:0];
        end
        if (i_cmd.mul_est || i_cmd.mul_var)
            r_prod <= mul_a * mul_b;
        if (i_cmd.out_load)
            r_out <= r_est;
    end

    a_out_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(i_cmd.out_load))
        else $error("result beat appeared without a load");

    a_started_after_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_first |=> (r_started && r_var == $past(r_init_var)))
        else $error("restart did not load the initial variance");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_out)))
        else $error("pending result beat was overwritten");

endmodule
`default_nettype wire

/* design/scalar_kalman_smoother.sv */
// Top level of the scalar Kalman smoother.
//
//  channel  direction  handshake                 payload
//  input    in         i_in_valid / o_in_stall   i_sample, i_first
//  output   out        o_out_valid / i_out_stall o_estimate
//  config   in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// A first-of-sequence beat is loaded as the estimate in the predict state and reaches the
// result register in the output state. Other beats pass the 16-step serial gain divider,
// then two passes through the shared 33x17 multiplier and the variance write-back.
// A beat is accepted only in idle; a held result keeps the next beat in its last state.
// Reset is synchronous, active low; config registers return to their defaults.
// One beat is in flight at a time; a held result does not block acceptance.
`default_nettype none
module scalar_kalman_smoother (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_in_valid,
    output logic                                  o_in_stall,
    input  wire  signed [skf_pkg::DATA_WIDTH-1:0] i_sample,
    input  wire                                   i_first,
    output logic                                  o_out_valid,
    input  wire                                   i_out_stall,
    output logic signed [skf_pkg::DATA_WIDTH-1:0] o_estimate,
    input  wire                                   i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire  [skf_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire  [skf_pkg::DATA_WIDTH-1:0]        i_cfg_data
);
    import skf_pkg::*;

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    skf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    skf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_sample    (i_sample),
        .i_first     (i_first),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_estimate  (o_estimate),
        .i_cmd       (cmd),
        .o_status    (status)
    );

endmodule
`default_nettype wire

/* test/tb_scalar_kalman_smoother.sv */
// Testbench for scalar_kalman_smoother: queued stimulus, bit-exact estimate predictor, checker.
`timescale 1ns / 1ps
module tb_scalar_kalman_smoother;
    import skf_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 30;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] sample;
        logic                         first;
    } t_sample_beat;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_in_valid = 1'b0;
    logic                         o_in_stall;
    logic signed [DATA_WIDTH-1:0] i_sample = '0;
    logic                         i_first = 1'b0;
    logic                         o_out_valid;
    logic                         i_out_stall = 1'b0;
    logic signed [DATA_WIDTH-1:0] o_estimate;
    logic                         i_cfg_valid = 1'b0;
    logic                         o_cfg_ready;
    t_reg_idx                     i_cfg_index = REG_PROC_VAR;
    logic [DATA_WIDTH-1:0]        i_cfg_data = '0;

    scalar_kalman_smoother dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_sample    (i_sample),
        .i_first     (i_first),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_estimate  (o_estimate),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // filter state and register copies, at their reset values
    logic [DATA_WIDTH-1:0]        q_var = PROC_VAR_RST;
    logic [DATA_WIDTH-1:0]        r_var = MEAS_VAR_RST;
    logic [DATA_WIDTH-1:0]        p0_var = INIT_VAR_RST;
    logic signed [DATA_WIDTH-1:0] est_q = '0;
    logic [DATA_WIDTH-1:0]        var_q = INIT_VAR_RST;
    logic                         seq_open = 1'b0;

    t_sample_beat                 pending_beats[$];
    logic signed [DATA_WIDTH-1:0] expected_estimates[$];
    t_sample_beat                 next_beat;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned error_count = 0;
    int unsigned checked_estimates = 0;
    int unsigned queued_samples = 0;
    int unsigned accepted_samples = 0;
    int unsigned seq_starts = 0;
    int unsigned sat_gain_updates = 0;
    int unsigned zero_gain_updates = 0;
    int unsigned settings_used = 0;
    int unsigned quiet_cycles = 0;

    initial forever #1 i_clk = ~i_clk;

    function automatic logic [DATA_WIDTH-1:0] sat_sum(logic [DATA_WIDTH-1:0] a,
                                                      logic [DATA_WIDTH-1:0] b);
        logic [DATA_WIDTH:0] s;
        s = a + b;
        return s[DATA_WIDTH] ? '1 : s[DATA_WIDTH-1:0];
    endfunction

    // One filter step; returns the estimate the block must produce for this beat.
    function automatic logic signed [DATA_WIDTH-1:0] kalman_update(
            logic signed [DATA_WIDTH-1:0] sample, logic first);
        logic [DATA_WIDTH-1:0] pred;
        logic [DATA_WIDTH-1:0] total;
        logic [GAIN_W-1:0]     gain;
        logic [DATA_WIDTH+1:0] rem;
        longint                diff;
        longint                next_est;
        longint unsigned       mag;
        longint unsigned       corr;
        longint unsigned       pred_l;
        longint unsigned       keep;
        if (first || !seq_open) begin
            est_q = sample;
            var_q = p0_var;
            seq_open = 1'b1;
            seq_starts++;
        end else begin
            pred = sat_sum(var_q, q_var);
            total = sat_sum(pred, r_var);
            if (pred >= total) begin
                gain = GAIN_MAX;
                sat_gain_updates++;
            end else begin
                // restoring division, one quotient bit per step
                rem = pred;
                gain = '0;
                for (int i = 0; i < FRAC_BITS; i++) begin
                    rem = rem << 1;
                    gain = gain << 1;
                    if (rem >= total) begin
                        rem = rem - total;
                        gain[0] = 1'b1;
                    end
                end
                if (gain == '0) zero_gain_updates++;
            end
            diff = longint'($signed(sample)) - longint'($signed(est_q));
            mag = (diff < 0) ? -diff : diff;
            corr = (mag * gain) >> FRAC_BITS;
            next_est = (diff < 0) ? longint'($signed(est_q)) - longint'(corr)
                                  : longint'($signed(est_q)) + longint'(corr);
            est_q = next_est[DATA_WIDTH-1:0];
            pred_l = pred;
            keep = GAIN_ONE;
            keep = keep - gain;
            var_q = DATA_WIDTH'((pred_l * keep) >> FRAC_BITS);
        end
        return est_q;
    endfunction

    // input side: beats come from the pending queue, predicted when accepted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                expected_estimates.insert(expected_estimates.size(),
                                          kalman_update(i_sample, i_first));
                accepted_samples++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_beat = pending_beats.pop_front();
                    i_in_valid <= 1'b1;
                    i_sample <= next_beat.sample;
                    i_first <= next_beat.first;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // output side: random stall, compare each estimate beat in order
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_estimates.size() == 0) begin
                $error("estimate beat with nothing pending: got %0d", o_estimate);
                error_count++;
            end else begin
                if (o_estimate !== expected_estimates[0]) begin
                    $error("estimate mismatch: expected %0d, got %0d",
                           expected_estimates[0], o_estimate);
                    error_count++;
                end
                void'(expected_estimates.pop_front());
                checked_estimates++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic queue_beat(logic [DATA_WIDTH-1:0] sample, logic first);
        t_sample_beat beat;
        beat.sample = sample;
        beat.first = first;
        pending_beats.insert(pending_beats.size(), beat);
        queued_samples++;
    endtask

    // every queued beat has come back and been checked, so nothing is in flight
    task automatic wait_for_idle();
        do @(posedge i_clk);
        while (checked_estimates != queued_samples);
    endtask

    // valid stays high between back-to-back writes; the caller lowers it
    task automatic write_reg(t_reg_idx idx, logic [DATA_WIDTH-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        case (idx)
            REG_PROC_VAR: q_var = val;
            REG_MEAS_VAR: r_var = val;
            REG_INIT_VAR: p0_var = val;
            default: ;
        endcase
    endtask

    task automatic configure(logic [DATA_WIDTH-1:0] q, logic [DATA_WIDTH-1:0] r,
                             logic [DATA_WIDTH-1:0] p0);
        write_reg(REG_PROC_VAR, q);
        write_reg(REG_MEAS_VAR, r);
        write_reg(REG_INIT_VAR, p0);
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [DATA_WIDTH-1:0] pick_variance();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return $urandom_range(0, 1 << 18);
            3: return $urandom;
            4: return $urandom >> $urandom_range(0, 31);
            default: return $urandom_range(1 << 10, 1 << 24);
        endcase
    endfunction

    function automatic logic [DATA_WIDTH-1:0] pick_sample();
        logic [DATA_WIDTH-1:0] v;
        case ($urandom_range(0, 3))
            0: v = $urandom;
            1: begin
                v = $urandom >> $urandom_range(1, 31);
                if ($urandom_range(0, 1)) v = -v;
            end
            2: case ($urandom_range(0, 3))
                0: v = 32'h7FFF_FFFF;
                1: v = 32'h8000_0000;
                2: v = '0;
                default: v = '1;
            endcase
            default: v = $urandom_range(0, 1 << 22) - (1 << 21);
        endcase
        return v;
    endfunction

    // mostly sequences that open with a first flag, noisy around a level;
    // a few flags are flipped to break or restart sequences
    task automatic queue_random_run(int unsigned n);
        int unsigned           left;
        int unsigned           seq_len;
        logic [DATA_WIDTH-1:0] level;
        logic [DATA_WIDTH-1:0] s;
        logic                  first;
        left = n;
        while (left > 0) begin
            level = pick_sample();
            seq_len = $urandom_range(1, 40);
            for (int k = 0; k < seq_len && left > 0; k++) begin
                first = (k == 0);
                if ($urandom_range(99) < 5) first = ~first;
                if (k == 0) s = level;
                else if ($urandom_range(99) < 70)
                    s = level + ($signed($urandom) >>> $urandom_range(6, 31));
                else s = pick_sample();
                queue_beat(s, first);
                left--;
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 37;
        recv_idle_pct = 80;

        // default registers; the opening beat has no first flag
        queue_beat(32'h0000_0000, 1'b0);
        queue_beat(32'h7FFF_FFFF, 1'b0);
        queue_beat(32'h8000_0000, 1'b0);
        queue_beat(32'h8000_0000, 1'b1);
        queue_beat(32'h7FFF_FFFF, 1'b0);
        queue_beat(32'hFFFF_FFFF, 1'b0);
        queue_beat(32'h0000_0001, 1'b1);
        queue_beat(32'h0001_0000, 1'b0);
        wait_for_idle();

        // both noise terms zero: gain pinned at its maximum
        configure('0, '0, '0);
        queue_beat(32'h0000_0005, 1'b1);
        queue_beat(32'h7FFF_FFFF, 1'b0);
        queue_beat(32'hFFFF_FFFF, 1'b0);
        wait_for_idle();

        // everything at full scale: both sums saturate
        configure('1, '1, '1);
        queue_beat(32'h8000_0000, 1'b1);
        queue_beat(32'h7FFF_FFFF, 1'b0);
        queue_beat(32'h0000_0000, 1'b0);
        wait_for_idle();

        // no prior uncertainty, huge measurement noise: gain of zero
        configure('0, '1, '0);
        queue_beat(32'h0000_03E8, 1'b1);
        queue_beat(32'h7FFF_FFFF, 1'b0);
        queue_beat(32'h8000_0000, 1'b0);
        wait_for_idle();

        configure(32'd1, 32'd1, '1);
        queue_beat(32'h0000_0000, 1'b1);
        queue_beat(32'hFFFF_FFFB, 1'b0);
        queue_beat(32'h0000_0007, 1'b0);
        wait_for_idle();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 80 : 0;
            recv_idle_pct = (phase == 0) ? 80 : (phase == 1) ? 37 : 0;
            for (int blk = 0; blk < 5; blk++) begin
                configure(pick_variance(), pick_variance(), pick_variance());
                queue_random_run(70);
                wait_for_idle();
            end
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Covered %0d samples in %0d sequence starts under %0d register settings,",
                 accepted_samples, seq_starts, settings_used + 1);
        $display("with %0d saturated-gain and %0d zero-gain updates; %0d estimates checked.",
                 sat_gain_updates, zero_gain_updates, checked_estimates);
        if (error_count == 0 && expected_estimates.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
